>>> rtl/tdwot_pkg.sv
package tdwot_pkg;

	// request kinds on the input channel
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_ADD    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	// result kinds on the output channel
	localparam logic [2:0] RES_SUMMARY   = 3'd0;
	localparam logic [2:0] RES_FIRED     = 3'd1;
	localparam logic [2:0] RES_ADD_OK    = 3'd2;
	localparam logic [2:0] RES_REMOVE_OK = 3'd3;
	localparam logic [2:0] RES_ERROR     = 3'd4;

	// prescaler constants
	localparam logic [20:0] SEC_MS       = 21'd1000;
	localparam logic [20:0] SEC_CLEAR_MS = 21'd2000;
	localparam logic [31:0] MIN_MS       = 32'd60000;
	localparam logic [5:0]  MIN_PER_HOUR = 6'd60;

	// slot fires once its count is at or below this
	localparam logic signed [32:0] FIRE_LIMIT = 33'sd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic                active;
		logic signed [32:0]  remaining;
		logic [15:0]         tag;
	} slot_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] interval;
		logic [30:0] delay;
		logic [15:0] tag;
		logic [3:0]  handle;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot_id;
		logic [15:0] fired_tag;
		logic        sec;
		logic        min;
		logic        hour;
	} res_t;

endpackage

>>> rtl/tdwot_cell.sv
module tdwot_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  tdwot_pkg::slot_t slot_in,
	output tdwot_pkg::slot_t slot_out
);

	logic        active_q;
	logic [32:0] remaining_q;
	logic [15:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift) begin
			active_q <= slot_in.active;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			remaining_q <= slot_in.remaining;
			tag_q       <= slot_in.tag;
		end
	end

	assign slot_out.active    = active_q;
	assign slot_out.remaining = $signed(remaining_q);
	assign slot_out.tag       = tag_q;

endmodule

>>> rtl/tdwot_head.sv
module tdwot_head #(
	parameter int IW = 4
) (
	input  tdwot_pkg::cmd_t  cmd,
	input  logic [IW-1:0]    idx,
	input  logic             found,
	input  tdwot_pkg::slot_t slot_in,
	output tdwot_pkg::slot_t slot_out,
	output logic             hit,
	output tdwot_pkg::res_t  res
);

	logic signed [32:0] dec;
	logic               fire;

	assign dec  = slot_in.remaining - $signed({13'd0, cmd.interval});
	assign fire = dec <= tdwot_pkg::FIRE_LIMIT;

	always_comb begin
		slot_out      = slot_in;
		hit           = 1'b0;
		res           = '0;
		res.slot_id   = 4'(idx);
		unique case (cmd.kind)
			tdwot_pkg::KIND_TICK: begin
				if (slot_in.active) begin
					slot_out.remaining = dec;
					if (fire) begin
						slot_out.active = 1'b0;
						hit             = 1'b1;
						res.kind        = tdwot_pkg::RES_FIRED;
						res.fired_tag   = slot_in.tag;
					end
				end
			end
			tdwot_pkg::KIND_ADD: begin
				// lowest free slot wins: the ring presents slots in ascending order
				if (!slot_in.active && !found) begin
					slot_out.active    = 1'b1;
					slot_out.remaining = $signed({2'b00, cmd.delay});
					slot_out.tag       = cmd.tag;
					hit                = 1'b1;
					res.kind           = tdwot_pkg::RES_ADD_OK;
				end
			end
			tdwot_pkg::KIND_REMOVE: begin
				if (slot_in.active && (32'(idx) == 32'(cmd.handle))) begin
					slot_out.active = 1'b0;
					hit             = 1'b1;
					res.kind        = tdwot_pkg::RES_REMOVE_OK;
					res.slot_id     = cmd.handle;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/tdwot_prescale.sv
module tdwot_prescale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [19:0] interval,
	output logic        sec_evt,
	output logic        min_evt,
	output logic        hour_evt
);

	logic [20:0] sec_q, sec_sum, sec_d;
	logic [31:0] min_q, min_sat, min_d;
	logic [32:0] min_sum;
	logic [5:0]  mod_q, mod_d;

	always_comb begin
		sec_sum  = sec_q + 21'(interval);
		min_sum  = {1'b0, min_q} + 33'(interval);
		min_sat  = min_sum[32] ? '1 : min_sum[31:0];
		sec_evt  = sec_sum >= tdwot_pkg::SEC_MS;
		min_evt  = sec_evt && (min_sat >= tdwot_pkg::MIN_MS);
		hour_evt = min_evt && (mod_q == tdwot_pkg::MIN_PER_HOUR - 6'd1);

		sec_d = sec_sum;
		if (sec_evt) begin
			// a big overshoot drops the remainder instead of carrying it
			sec_d = (sec_sum > tdwot_pkg::SEC_CLEAR_MS) ? '0 : sec_sum - tdwot_pkg::SEC_MS;
		end
		min_d = min_evt ? min_sat - tdwot_pkg::MIN_MS : min_sat;
		mod_d = mod_q;
		if (min_evt) begin
			mod_d = hour_evt ? '0 : mod_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
			min_q <= '0;
			mod_q <= '0;
		end else if (step) begin
			sec_q <= sec_d;
			min_q <= min_d;
			mod_q <= mod_d;
		end
	end

endmodule

>>> rtl/tick_divider_with_oneshot_timers.sv
// One-shot timer bank with a millisecond prescaler. Each request is a tick
// (elapsed ms), an add (claim the lowest free slot with a delay and a tag) or
// a remove (free a slot by handle). The slots live in a ring of SLOT_COUNT
// cells; every tick, add or remove rotates the ring once, one slot per cycle
// unless a parked result waits on a full output register, through a single
// update unit at the head: the request is accepted, the ring makes
// SLOT_COUNT steps, then one flush follows. An add or remove that ends in an
// error builds that error in the flush state first; an unknown kind skips
// the ring and goes straight to the flush. The ring rotation is the rate limit.
// A tick returns a summary with the second/minute/hour events first, then one
// fired result per expiring slot in ascending slot order; add and remove
// return one result. The last flag marks the final result of a request. The
// next request is taken only when the previous one has handed all its results
// to the output register, which may still be waiting on out_ready.
module tick_divider_with_oneshot_timers #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [19:0] interval_ms,
	input  logic [30:0] delay_ms,
	input  logic [15:0] target_tag,
	input  logic [3:0]  slot_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [3:0]  slot_id,
	output logic [15:0] fired_tag,
	output logic        second_event,
	output logic        minute_event,
	output logic        hour_event,
	output logic        last
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	tdwot_pkg::seq_state_t state_q, state_d;

	logic [IW-1:0]    idx_q;
	logic             found_q;
	tdwot_pkg::cmd_t  cmd_q;

	// held result: its last flag is known only when the next one shows up
	logic             pend_valid_q, pend_valid_d;
	tdwot_pkg::res_t  pend_q, pend_d;

	logic             out_valid_q;
	tdwot_pkg::res_t  out_q;
	logic             out_last_q;
	logic             out_load, out_last_d;

	logic             accept, advance, out_free;
	logic             sec_evt, min_evt, hour_evt;

	tdwot_pkg::slot_t cell_out [SLOT_COUNT];
	tdwot_pkg::slot_t head_out;
	logic             head_hit;
	tdwot_pkg::res_t  head_res;

	assign in_ready = (state_q == tdwot_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	// a ring step may produce a result, so hold the ring while one is parked
	// and the output register cannot take it
	assign advance  = (state_q == tdwot_pkg::ST_PASS) && !(pend_valid_q && !out_free);

	// prescaler updates on every accepted tick
	tdwot_prescale u_prescale (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept && (kind == tdwot_pkg::KIND_TICK)),
		.interval (interval_ms),
		.sec_evt  (sec_evt),
		.min_evt  (min_evt),
		.hour_evt (hour_evt)
	);

	// ring of slot cells: cell 0 feeds the head, the head writes the last cell
	genvar k;
	generate
		for (k = 0; k < SLOT_COUNT; k++) begin : g_cell
			tdwot_pkg::slot_t cell_in;
			if (k == SLOT_COUNT - 1) begin : g_tail
				assign cell_in = head_out;
			end else begin : g_mid
				assign cell_in = cell_out[k + 1];
			end
			tdwot_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (advance),
				.slot_in  (cell_in),
				.slot_out (cell_out[k])
			);
		end
	endgenerate

	tdwot_head #(
		.IW (IW)
	) u_head (
		.cmd      (cmd_q),
		.idx      (idx_q),
		.found    (found_q),
		.slot_in  (cell_out[0]),
		.slot_out (head_out),
		.hit      (head_hit),
		.res      (head_res)
	);

	// sequencer: next state and result routing
	always_comb begin
		state_d      = state_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		out_load     = 1'b0;
		out_last_d   = 1'b0;
		unique case (state_q)
			tdwot_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kind) inside
						tdwot_pkg::KIND_TICK: begin
							pend_valid_d = 1'b1;
							pend_d       = '0;
							pend_d.kind  = tdwot_pkg::RES_SUMMARY;
							pend_d.sec   = sec_evt;
							pend_d.min   = min_evt;
							pend_d.hour  = hour_evt;
							state_d      = tdwot_pkg::ST_PASS;
						end
						tdwot_pkg::KIND_ADD, tdwot_pkg::KIND_REMOVE: begin
							pend_valid_d = 1'b0;
							state_d      = tdwot_pkg::ST_PASS;
						end
						default: begin
							// unknown request kind: error, no ring pass
							pend_valid_d = 1'b1;
							pend_d       = '0;
							pend_d.kind  = tdwot_pkg::RES_ERROR;
							state_d      = tdwot_pkg::ST_FLUSH;
						end
					endcase
				end
			end
			tdwot_pkg::ST_PASS: begin
				if (advance) begin
					if (head_hit) begin
						out_load     = pend_valid_q;
						pend_valid_d = 1'b1;
						pend_d       = head_res;
					end
					if (idx_q == LAST_IDX) begin
						state_d = tdwot_pkg::ST_FLUSH;
					end
				end
			end
			tdwot_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					// add on a full table, or remove of a free or out-of-range slot
					pend_valid_d = 1'b1;
					pend_d       = '0;
					pend_d.kind  = tdwot_pkg::RES_ERROR;
					if (cmd_q.kind == tdwot_pkg::KIND_REMOVE) begin
						pend_d.slot_id = cmd_q.handle;
					end
				end else if (out_free) begin
					out_load     = 1'b1;
					out_last_d   = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = tdwot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdwot_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tdwot_pkg::ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			found_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + IW'(1);
				if (head_hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.kind     <= kind;
			cmd_q.interval <= interval_ms;
			cmd_q.delay    <= delay_ms;
			cmd_q.tag      <= target_tag;
			cmd_q.handle   <= slot_handle;
		end
		pend_q <= pend_d;
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign slot_id      = out_q.slot_id;
	assign fired_tag    = out_q.fired_tag;
	assign second_event = out_q.sec;
	assign minute_event = out_q.min;
	assign hour_event   = out_q.hour;
	assign last         = out_last_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the one-shot timer bank with its ms prescaler.
// Requests are prebuilt into a backlog that a negedge driver plays out with
// random gaps. A posedge monitor runs the software bank model on every
// accepted request and checks each result in order against what it predicts.
module tb;

	localparam int SLOTS = 16;
	// kind code 3 is not decoded by the block; it must answer with an error
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [19:0] TICK_MAX = 20'hFFFFF;

	localparam int RANDOM_REQS = 450;
	localparam int MAX_REQS = 600;
	localparam int MAX_RESULTS = SLOTS + 1;
	localparam int GAP_MAX = 40;
	localparam int STALL_MAX = 40;
	localparam int TAIL_CYCLES = 4 * (SLOTS + 2);
	// worst case per request: ring pass, every result behind the longest
	// stall, the longest sender gap; then margin on top
	localparam longint CYCLE_LIMIT = 3 * longint'(MAX_REQS) *
		longint'(SLOTS + 2 + MAX_RESULTS * (STALL_MAX + 1) + GAP_MAX) + 10000;

	typedef struct packed {
		tdwot_pkg::res_t body;
		logic last;
	} timer_result_t;

	typedef struct packed {
		tdwot_pkg::cmd_t cmd;
		logic [7:0]      gap;
		logic            drain;
	} pending_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [19:0] interval_ms = '0;
	logic [30:0] delay_ms = '0;
	logic [15:0] target_tag = '0;
	logic [3:0]  slot_handle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  result_kind;
	logic [3:0]  slot_id;
	logic [15:0] fired_tag;
	logic        second_event;
	logic        minute_event;
	logic        hour_event;
	logic        last;

	tick_divider_with_oneshot_timers #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.interval_ms(interval_ms),
		.delay_ms(delay_ms),
		.target_tag(target_tag),
		.slot_handle(slot_handle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.slot_id(slot_id),
		.fired_tag(fired_tag),
		.second_event(second_event),
		.minute_event(minute_event),
		.hour_event(hour_event),
		.last(last)
	);

	always #1 clk = ~clk;

	// Bank model state, mirrored at the block's widths.
	logic               bank_active [SLOTS];
	logic signed [32:0] bank_left [SLOTS];
	logic [15:0]        bank_tag [SLOTS];
	logic [20:0]        sec_acc;
	logic [31:0]        min_acc;
	logic [5:0]         min_count;

	pending_req_t  req_backlog[$];
	timer_result_t due_results[$];

	int     n_issued = 0;
	int     n_accepted = 0;
	int     held_cycles = 0;
	int     n_failures = 0;
	int     stall_left = 0;
	int     ready_roll;
	longint cycle_count = 0;
	pending_req_t  nxt_req;
	timer_result_t got;
	timer_result_t want;

	function automatic string show_result(input timer_result_t t);
		return $sformatf("kind=%0d slot=%0d tag=%h sec=%b min=%b hour=%b last=%b",
			t.body.kind, t.body.slot_id, t.body.fired_tag, t.body.sec, t.body.min,
			t.body.hour, t.last);
	endfunction

	task automatic note_failure(input string msg);
		n_failures++;
		if (n_failures <= 10)
			$display("%s", msg);
	endtask

	// Apply one request to the bank model and queue the results it causes.
	task automatic advance_timer_bank(input tdwot_pkg::cmd_t c);
		timer_result_t produced[$];
		timer_result_t r;
		logic [32:0]   min_sum;
		bit            found;
		int            i;
		r = '0;
		found = 1'b0;
		case (c.kind)
		tdwot_pkg::KIND_TICK: begin
			// minute accumulator saturates instead of wrapping
			min_sum = {1'b0, min_acc} + {13'd0, c.interval};
			min_acc = min_sum[32] ? 32'hFFFF_FFFF : min_sum[31:0];
			sec_acc = sec_acc + {1'b0, c.interval};
			r.body.kind = tdwot_pkg::RES_SUMMARY;
			if (sec_acc >= tdwot_pkg::SEC_MS) begin
				r.body.sec = 1'b1;
				// far overshoot drops the remainder
				if (sec_acc > tdwot_pkg::SEC_CLEAR_MS)
					sec_acc = '0;
				else
					sec_acc = sec_acc - tdwot_pkg::SEC_MS;
				// minutes only advance on a second boundary
				if (min_acc >= tdwot_pkg::MIN_MS) begin
					r.body.min = 1'b1;
					min_count = min_count + 6'd1;
					if (min_count >= tdwot_pkg::MIN_PER_HOUR) begin
						r.body.hour = 1'b1;
						min_count = '0;
					end
					min_acc = min_acc - tdwot_pkg::MIN_MS;
				end
			end
			produced.push_back(r);
			// countdown in slot order; expiring slots report and free up
			for (i = 0; i < SLOTS; i++) begin
				if (bank_active[i]) begin
					bank_left[i] = bank_left[i] - $signed({13'd0, c.interval});
					if (bank_left[i] <= tdwot_pkg::FIRE_LIMIT) begin
						bank_active[i] = 1'b0;
						r = '0;
						r.body.kind = tdwot_pkg::RES_FIRED;
						r.body.slot_id = i[3:0];
						r.body.fired_tag = bank_tag[i];
						produced.push_back(r);
					end
				end
			end
		end
		tdwot_pkg::KIND_ADD: begin
			// lowest free slot wins
			for (i = 0; i < SLOTS && !found; i++) begin
				if (!bank_active[i]) begin
					bank_active[i] = 1'b1;
					bank_left[i] = $signed({2'b00, c.delay});
					bank_tag[i] = c.tag;
					found = 1'b1;
					r.body.kind = tdwot_pkg::RES_ADD_OK;
					r.body.slot_id = i[3:0];
				end
			end
			if (!found)
				r.body.kind = tdwot_pkg::RES_ERROR;
			produced.push_back(r);
		end
		tdwot_pkg::KIND_REMOVE: begin
			// error echoes the handle back, state untouched
			if (int'(c.handle) < SLOTS && bank_active[c.handle]) begin
				bank_active[c.handle] = 1'b0;
				r.body.kind = tdwot_pkg::RES_REMOVE_OK;
			end else begin
				r.body.kind = tdwot_pkg::RES_ERROR;
			end
			r.body.slot_id = c.handle;
			produced.push_back(r);
		end
		default: begin
			r.body.kind = tdwot_pkg::RES_ERROR;
			produced.push_back(r);
		end
		endcase
		produced[produced.size() - 1].last = 1'b1;
		foreach (produced[k])
			due_results.push_back(produced[k]);
	endtask

	// Sender gaps: mostly back to back, some short, a few long.
	function automatic logic [7:0] pick_gap(input bit calm);
		int unsigned roll;
		int unsigned g;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			g = 0;
		else if (roll < 90)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(8, GAP_MAX);
		return g[7:0];
	endfunction

	// Every field random; callers then fix what the request needs.
	function automatic tdwot_pkg::cmd_t rand_cmd();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[72:0];
	endfunction

	function automatic logic [19:0] rand_interval();
		logic [31:0] u;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			u = $urandom_range(0, 2);
		else if (roll < 50)
			u = $urandom_range(0, 1500);
		else if (roll < 80)
			u = $urandom_range(0, 100000);
		else
			u = $urandom();
		return u[19:0];
	endfunction

	// Delays mostly in reach of the ticks so that slots actually expire.
	function automatic logic [30:0] rand_delay();
		logic [31:0] u;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			u = $urandom_range(0, 3);
		else if (roll < 60)
			u = $urandom_range(0, 5000);
		else if (roll < 85)
			u = $urandom_range(0, 200000);
		else
			u = $urandom();
		return u[30:0];
	endfunction

	task automatic queue_req(input tdwot_pkg::cmd_t c, input bit drain, input bit calm);
		pending_req_t p;
		p.cmd = c;
		p.gap = pick_gap(calm);
		p.drain = drain;
		req_backlog.push_back(p);
	endtask

	// Driver: a request stays up until taken, then the next one follows
	// after its gap. A drain request waits for every result outstanding.
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_accepted == n_issued) begin
				if (req_backlog.size() == 0) begin
					in_valid <= 1'b0;
				end else if (held_cycles < int'(req_backlog[0].gap) ||
						(req_backlog[0].drain && due_results.size() != 0)) begin
					in_valid <= 1'b0;
					held_cycles <= held_cycles + 1;
				end else begin
					nxt_req = req_backlog.pop_front();
					{kind, interval_ms, delay_ms, target_tag, slot_handle} <= nxt_req.cmd;
					in_valid <= 1'b1;
					n_issued <= n_issued + 1;
					held_cycles <= 0;
				end
			end
		end
	end

	// Receiver back-pressure: short and long stalls, with calm windows.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ((cycle_count % 3000) < 500) begin
				out_ready <= 1'b1;
			end else begin
				ready_roll = $urandom_range(0, 99);
				if (ready_roll < 70) begin
					out_ready <= 1'b1;
				end else if (ready_roll < 93) begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(0, 2);
				end else begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(8, STALL_MAX);
				end
			end
		end
	end

	// Monitor: predict on request acceptance, compare on result acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_timer_bank({kind, interval_ms, delay_ms, target_tag, slot_handle});
				n_accepted <= n_accepted + 1;
			end
			if (out_valid && out_ready) begin
				got = {result_kind, slot_id, fired_tag, second_event, minute_event,
					hour_event, last};
				if (due_results.size() == 0) begin
					note_failure($sformatf("unexpected result: %s", show_result(got)));
				end else begin
					want = due_results.pop_front();
					if (got !== want)
						note_failure($sformatf("mismatch: expected %s, got %s",
							show_result(want), show_result(got)));
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		tdwot_pkg::cmd_t c;
		int              n;
		int              roll;

		for (n = 0; n < SLOTS; n++) begin
			bank_active[n] = 1'b0;
			bank_left[n] = '0;
			bank_tag[n] = '0;
		end
		sec_acc = '0;
		min_acc = '0;
		min_count = '0;

		// --- directed opening ---
		// undecoded kind, remove of a free slot, empty tick
		c = rand_cmd();
		c.kind = KIND_UNKNOWN;
		queue_req(c, 1'b0, 1'b0);
		c = rand_cmd();
		c.kind = tdwot_pkg::KIND_REMOVE;
		c.handle = 4'd15;
		queue_req(c, 1'b0, 1'b0);
		c = rand_cmd();
		c.kind = tdwot_pkg::KIND_TICK;
		c.interval = '0;
		queue_req(c, 1'b0, 1'b0);
		// fill the table: zero, one and two ms delays, the longest delay,
		// tags at both ends
		for (n = 0; n < SLOTS; n++) begin
			c = rand_cmd();
			c.kind = tdwot_pkg::KIND_ADD;
			case (n)
			0: begin c.delay = 31'd0; c.tag = 16'h0000; end
			1: begin c.delay = 31'd1; c.tag = 16'hFFFF; end
			2: c.delay = 31'd2;
			3: c.delay = 31'h7FFF_FFFF;
			default: c.delay = rand_delay();
			endcase
			queue_req(c, 1'b0, 1'b0);
		end
		// full table rejects the add
		c = rand_cmd();
		c.kind = tdwot_pkg::KIND_ADD;
		queue_req(c, 1'b0, 1'b0);
		c = rand_cmd();
		c.kind = tdwot_pkg::KIND_REMOVE;
		c.handle = 4'd3;
		queue_req(c, 1'b0, 1'b0);
		// zero-ms tick still fires the zero and one ms slots; then the
		// second boundary cases: just short, exact, exactly two seconds
		// (keeps a second), just over two seconds (clears), and the widest tick
		c = rand_cmd();
		c.kind = tdwot_pkg::KIND_TICK;
		c.interval = 20'd0;
		queue_req(c, 1'b0, 1'b0);
		c.interval = 20'd999;
		queue_req(c, 1'b0, 1'b0);
		c.interval = 20'd1;
		queue_req(c, 1'b0, 1'b0);
		c.interval = 20'd2000;
		queue_req(c, 1'b0, 1'b0);
		c.interval = 20'd1001;
		queue_req(c, 1'b0, 1'b0);
		c.interval = TICK_MAX;
		queue_req(c, 1'b0, 1'b0);

		// --- random mix, mostly well-formed adds/removes/ticks ---
		for (n = 0; n < RANDOM_REQS; n++) begin
			c = rand_cmd();
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				c.kind = KIND_UNKNOWN;
			end else if (roll < 40) begin
				c.kind = tdwot_pkg::KIND_ADD;
				c.delay = rand_delay();
			end else if (roll < 65) begin
				c.kind = tdwot_pkg::KIND_REMOVE;
			end else begin
				c.kind = tdwot_pkg::KIND_TICK;
				c.interval = rand_interval();
			end
			// drain before the random part and once in the middle of it
			queue_req(c, n == 0 || n == RANDOM_REQS / 2, (n % 90) < 20);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || n_accepted != n_issued ||
				due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);

		while (due_results.size() != 0) begin
			want = due_results.pop_front();
			note_failure($sformatf("missing result: expected %s", show_result(want)));
		end

		if (n_failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> tick_divider_with_oneshot_timers.f
rtl/tdwot_pkg.sv
rtl/tdwot_cell.sv
rtl/tdwot_head.sv
rtl/tdwot_prescale.sv
rtl/tick_divider_with_oneshot_timers.sv
sim/tb.sv
